// ===== rtl/catmull_rom_path_eval_unit_assert.svh =====
// Assertion macros for the Catmull-Rom path evaluator.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef CATMULL_ROM_PATH_EVAL_UNIT_ASSERT_SVH
`define CATMULL_ROM_PATH_EVAL_UNIT_ASSERT_SVH

// same-cycle implication
`define CRP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crp assertion failed");

// next-cycle implication
`define CRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crp assertion failed");

`endif

// ===== rtl/crp_pkg.sv =====
// Shared constants and types of the Catmull-Rom path evaluator.
// No dependencies; used by every module of the block.
package crp_pkg;

   localparam int COORD_W     = 32;
   localparam int POS_W       = 16;
   localparam int IDX_W       = 4;
   localparam int MAX_POINTS  = 1 << IDX_W;
   localparam int CNT_W       = 5;
   localparam int FRAC_BITS   = 16;
   localparam int LANES       = 4;
   localparam int POINT_W     = LANES * COORD_W;
   localparam int ACC_W       = COORD_W + 6;
   localparam int PROD_W      = ACC_W + FRAC_BITS + 1;
   localparam int LANE_STAGES = 5;

   localparam logic [CNT_W-1:0] PCOUNT_RESET = CNT_W'(2);
   localparam logic [CNT_W-1:0] PCOUNT_MIN   = CNT_W'(2);
   localparam logic [CNT_W-1:0] PCOUNT_MAX   = CNT_W'(MAX_POINTS);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic [LANE_STAGES-1:0] en;
   } crp_stage_en_type;

   typedef struct packed {
      logic                 valid;
      logic [FRAC_BITS-1:0] t;
      logic [POINT_W-1:0]   p0;
      logic [POINT_W-1:0]   p1;
      logic [POINT_W-1:0]   p2;
      logic [POINT_W-1:0]   p3;
   } crp_fetch_out_type;

endpackage

// ===== rtl/crp_fetch.sv =====
// Control-point store, point_count register and segment/index logic.
// Depends on crp_pkg and catmull_rom_path_eval_unit_assert.svh.
`include "catmull_rom_path_eval_unit_assert.svh"

module crp_fetch (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [crp_pkg::IDX_W-1:0]           req_point_index,
   input  logic signed [crp_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [crp_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [crp_pkg::COORD_W-1:0]  req_coord_z,
   input  logic signed [crp_pkg::COORD_W-1:0]  req_coord_w,
   input  logic [crp_pkg::POS_W-1:0]           req_position,
   input  logic                                csr_write_enable,
   input  logic [crp_pkg::CNT_W-1:0]           csr_write_data,
   input  logic                                dn_ready,
   output crp_pkg::crp_fetch_out_type          fout
);

   localparam int S_W = crp_pkg::POS_W + crp_pkg::IDX_W;

   logic [crp_pkg::POINT_W-1:0] mem [crp_pkg::MAX_POINTS];

   logic [crp_pkg::CNT_W-1:0]     point_count_ff;
   logic                          busy_ff, busy_in;
   logic                          fv_ff, fv_in;
   logic [crp_pkg::POINT_W-1:0]   ra0_ff, ra1_ff;
   logic [crp_pkg::IDX_W-1:0]     inx_ff, inn_ff;
   logic [crp_pkg::FRAC_BITS-1:0] t_ff;
   logic [crp_pkg::FRAC_BITS-1:0] t_out_ff;
   logic [crp_pkg::POINT_W-1:0]   p0_ff, p1_ff, p2_ff, p3_ff;

   logic [crp_pkg::IDX_W-1:0]     last_c, seg_raw_c, seg_c, ip_c, inx_c, inn_c;
   logic [S_W-1:0]                s_c;
   logic [crp_pkg::POS_W+crp_pkg::FRAC_BITS-1:0] t_wide_c;
   logic [crp_pkg::IDX_W:0]       nx1_c, nx2_c;
   logic                          accept, acc_eval, acc_load, out_load, phase_b;

   always_comb begin
      if (point_count_ff < crp_pkg::PCOUNT_MIN) begin
         last_c = crp_pkg::IDX_W'(crp_pkg::PCOUNT_MIN - crp_pkg::CNT_W'(1));
      end else if (point_count_ff > crp_pkg::PCOUNT_MAX) begin
         last_c = crp_pkg::IDX_W'(crp_pkg::PCOUNT_MAX - crp_pkg::CNT_W'(1));
      end else begin
         last_c = crp_pkg::IDX_W'(point_count_ff - crp_pkg::CNT_W'(1));
      end
      s_c       = S_W'(req_position) * S_W'(last_c);
      seg_raw_c = s_c[S_W-1:crp_pkg::POS_W];
      t_wide_c  = {s_c[crp_pkg::POS_W-1:0], {crp_pkg::FRAC_BITS{1'b0}}} >> crp_pkg::POS_W;
      seg_c     = (seg_raw_c > last_c) ? last_c : seg_raw_c;
      ip_c      = (seg_c == '0) ? '0 : seg_c - crp_pkg::IDX_W'(1);
      nx1_c     = {1'b0, seg_c} + (crp_pkg::IDX_W+1)'(1);
      nx2_c     = {1'b0, seg_c} + (crp_pkg::IDX_W+1)'(2);
      inx_c     = (nx1_c > {1'b0, last_c}) ? last_c : nx1_c[crp_pkg::IDX_W-1:0];
      inn_c     = (nx2_c > {1'b0, last_c}) ? last_c : nx2_c[crp_pkg::IDX_W-1:0];
   end

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign acc_eval  = accept && (req_kind == crp_pkg::KIND_EVAL);
   assign acc_load  = accept && (req_kind == crp_pkg::KIND_LOAD);
   assign out_load  = !fv_ff || dn_ready;
   assign phase_b   = busy_ff && out_load;

   always_comb begin
      busy_in = busy_ff;
      if (acc_eval) begin
         busy_in = 1'b1;
      end else if (phase_b) begin
         busy_in = 1'b0;
      end
      fv_in = fv_ff;
      if (phase_b) begin
         fv_in = 1'b1;
      end else if (dn_ready) begin
         fv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= crp_pkg::PCOUNT_RESET;
         busy_ff        <= 1'b0;
         fv_ff          <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            point_count_ff <= csr_write_data;
         end
         busy_ff <= busy_in;
         fv_ff   <= fv_in;
      end
   end

   // two read ports: first pair on accept, second pair on hand-over
   always_ff @(posedge clock) begin
      if (acc_load) begin
         mem[req_point_index] <= {req_coord_w, req_coord_z, req_coord_y, req_coord_x};
      end
      if (acc_eval) begin
         ra0_ff <= mem[ip_c];
         ra1_ff <= mem[seg_c];
         inx_ff <= inx_c;
         inn_ff <= inn_c;
         t_ff   <= t_wide_c[crp_pkg::FRAC_BITS-1:0];
      end
      if (phase_b) begin
         p0_ff    <= ra0_ff;
         p1_ff    <= ra1_ff;
         p2_ff    <= mem[inx_ff];
         p3_ff    <= mem[inn_ff];
         t_out_ff <= t_ff;
      end
   end

   assign fout.valid = fv_ff;
   assign fout.t     = t_out_ff;
   assign fout.p0    = p0_ff;
   assign fout.p1    = p1_ff;
   assign fout.p2    = p2_ff;
   assign fout.p3    = p3_ff;

   `CRP_ASSERT_NEXT(a_eval_opens_read, clock, reset, acc_eval, busy_ff)
   `CRP_ASSERT_NEXT(a_load_stays_free, clock, reset, acc_load, !busy_ff)
   `CRP_ASSERT_NEXT(a_read_hands_over, clock, reset, phase_b, fv_ff && !busy_ff)

endmodule

// ===== rtl/crp_lane.sv =====
// One component lane: Catmull-Rom coefficients and Horner evaluation in t.
// Depends on crp_pkg; stage enables come from the top-level valid chain.
module crp_lane (
   input  logic                               clock,
   input  crp_pkg::crp_stage_en_type          ctl,
   input  logic signed [crp_pkg::COORD_W-1:0] p0,
   input  logic signed [crp_pkg::COORD_W-1:0] p1,
   input  logic signed [crp_pkg::COORD_W-1:0] p2,
   input  logic signed [crp_pkg::COORD_W-1:0] p3,
   input  logic [crp_pkg::FRAC_BITS-1:0]      t,
   output logic signed [crp_pkg::ACC_W-1:0]   acc
);

   localparam int AW = crp_pkg::ACC_W;
   localparam int FB = crp_pkg::FRAC_BITS;

   logic signed [AW-1:0] e0, e1, e2, e3;
   logic signed [AW-1:0] a_in, b_in, c_in, d_in;

   logic signed [AW-1:0] a1_ff, b1_ff, c1_ff, d1_ff;
   logic [FB-1:0]        t1_ff;
   logic signed [AW-1:0] a2_ff, b2_ff, c2_ff, m1_ff;
   logic [FB-1:0]        t2_ff;
   logic signed [AW-1:0] a3_ff, b3_ff, m2_ff;
   logic [FB-1:0]        t3_ff;
   logic signed [AW-1:0] a4_ff, m3_ff;
   logic signed [AW-1:0] acc_ff;

   logic signed [crp_pkg::PROD_W-1:0] prod1, prod2, prod3;
   logic signed [AW-1:0]              sum2, sum3;

   always_comb begin
      e0   = AW'(p0);
      e1   = AW'(p1);
      e2   = AW'(p2);
      e3   = AW'(p3);
      a_in = e1 <<< 1;
      b_in = e2 - e0;
      c_in = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
      d_in = ((e1 <<< 1) + e1) - e0 - ((e2 <<< 1) + e2) + e3;
      prod1 = d1_ff * $signed({1'b0, t1_ff});
      sum2  = c2_ff + m1_ff;
      prod2 = sum2 * $signed({1'b0, t2_ff});
      sum3  = b3_ff + m2_ff;
      prod3 = sum3 * $signed({1'b0, t3_ff});
   end

   // products are floored by taking the bits above the fraction
   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         a1_ff <= a_in;
         b1_ff <= b_in;
         c1_ff <= c_in;
         d1_ff <= d_in;
         t1_ff <= t;
      end
      if (ctl.en[1]) begin
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
         c2_ff <= c1_ff;
         m1_ff <= prod1[AW+FB-1:FB];
         t2_ff <= t1_ff;
      end
      if (ctl.en[2]) begin
         a3_ff <= a2_ff;
         b3_ff <= b2_ff;
         m2_ff <= prod2[AW+FB-1:FB];
         t3_ff <= t2_ff;
      end
      if (ctl.en[3]) begin
         a4_ff <= a3_ff;
         m3_ff <= prod3[AW+FB-1:FB];
      end
      if (ctl.en[4]) begin
         acc_ff <= a4_ff + m3_ff;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/crp_merge.sv =====
// Merge stage: halves and saturates the four lane sums into the result word.
// Depends on crp_pkg; holds the result register and its valid/ready side.
module crp_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               lane_valid,
   input  logic signed [crp_pkg::ACC_W-1:0]   lane_acc [crp_pkg::LANES],
   output logic                               take,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [crp_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [crp_pkg::COORD_W-1:0] rsp_out_y,
   output logic signed [crp_pkg::COORD_W-1:0] rsp_out_z,
   output logic signed [crp_pkg::COORD_W-1:0] rsp_out_w
);

   localparam int AW = crp_pkg::ACC_W;
   localparam int CW = crp_pkg::COORD_W;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        res_ff [crp_pkg::LANES];
   logic [CW-1:0]        sat_c  [crp_pkg::LANES];
   logic [AW-2:0]        half_c [crp_pkg::LANES];

   always_comb begin
      for (int k = 0; k < crp_pkg::LANES; k++) begin
         half_c[k] = lane_acc[k][AW-1:1];
         if ((&half_c[k][AW-2:CW-1]) || !(|half_c[k][AW-2:CW-1])) begin
            sat_c[k] = half_c[k][CW-1:0];
         end else if (half_c[k][AW-2]) begin
            sat_c[k] = crp_pkg::COORD_MIN;
         end else begin
            sat_c[k] = crp_pkg::COORD_MAX;
         end
      end
   end

   assign take         = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = take ? lane_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && lane_valid) begin
         for (int k = 0; k < crp_pkg::LANES; k++) begin
            res_ff[k] <= sat_c[k];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = res_ff[0];
   assign rsp_out_y = res_ff[1];
   assign rsp_out_z = res_ff[2];
   assign rsp_out_w = res_ff[3];

endmodule

// ===== rtl/catmull_rom_path_eval_unit.sv =====
// Uniform Catmull-Rom path evaluator. A load word (kind 0) writes one
// four-component Q16.16 control point into a 16-entry store and is taken every
// cycle while no evaluate is in progress. An evaluate word (kind 1) reads four
// neighbouring points through the store's two read ports, two on accept, two on
// hand-over, and no new word is taken before the hand-over; four lanes then run
// the cubic in a 5-stage pipeline and a merge stage saturates the result. The
// user must write point_count only while idle; the block does not enforce this.
// Depends on crp_pkg, crp_fetch, crp_lane and crp_merge.
module catmull_rom_path_eval_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [crp_pkg::IDX_W-1:0]          req_point_index,
   input  logic signed [crp_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [crp_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [crp_pkg::COORD_W-1:0] req_coord_z,
   input  logic signed [crp_pkg::COORD_W-1:0] req_coord_w,
   input  logic [crp_pkg::POS_W-1:0]          req_position,
   input  logic                               csr_write_enable,
   input  logic [crp_pkg::CNT_W-1:0]          csr_write_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [crp_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [crp_pkg::COORD_W-1:0] rsp_out_y,
   output logic signed [crp_pkg::COORD_W-1:0] rsp_out_z,
   output logic signed [crp_pkg::COORD_W-1:0] rsp_out_w
);

   localparam int LS = crp_pkg::LANE_STAGES;
   localparam int CW = crp_pkg::COORD_W;

   crp_pkg::crp_fetch_out_type fout;
   crp_pkg::crp_stage_en_type  ctl;
   logic [LS-1:0]              stage_v_ff, stage_v_in;
   logic                       take;
   logic signed [crp_pkg::ACC_W-1:0] lane_acc [crp_pkg::LANES];

   crp_fetch u_fetch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_point_index  (req_point_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_coord_w      (req_coord_w),
      .req_position     (req_position),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .dn_ready         (ctl.en[0]),
      .fout             (fout)
   );

   // stage enable chain; bubbles close up under a stall
   always_comb begin
      ctl.en[LS-1] = !stage_v_ff[LS-1] || take;
      for (int k = LS - 2; k >= 0; k--) begin
         ctl.en[k] = !stage_v_ff[k] || ctl.en[k+1];
      end
      stage_v_in[0] = ctl.en[0] ? fout.valid : stage_v_ff[0];
      for (int k = 1; k < LS; k++) begin
         stage_v_in[k] = ctl.en[k] ? stage_v_ff[k-1] : stage_v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else begin
         stage_v_ff <= stage_v_in;
      end
   end

   for (genvar k = 0; k < crp_pkg::LANES; k++) begin : g_lane
      crp_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .p0    (fout.p0[k*CW +: CW]),
         .p1    (fout.p1[k*CW +: CW]),
         .p2    (fout.p2[k*CW +: CW]),
         .p3    (fout.p3[k*CW +: CW]),
         .t     (fout.t),
         .acc   (lane_acc[k])
      );
   end

   crp_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_valid (stage_v_ff[LS-1]),
      .lane_acc   (lane_acc),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_out_x  (rsp_out_x),
      .rsp_out_y  (rsp_out_y),
      .rsp_out_z  (rsp_out_z),
      .rsp_out_w  (rsp_out_w)
   );

endmodule
